// ----- rtl/sha_pkg.sv -----
`default_nettype none
package sha_pkg;
	localparam int WordW = 32;
	localparam int Rounds = 64;

	localparam logic [31:0] PadWord = 32'h8000_0000;

	typedef logic [31:0] word_t;

	// Datapath command set issued by the controller.
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_PUT   = 3'd1,  // store word at fill, fill++
		CMD_ZERO  = 3'd2,  // store zero at fill, fill++
		CMD_LEN   = 3'd3,  // store length word at fill, fill++
		CMD_START = 3'd4,  // load working vars from chaining value
		CMD_ROUND = 3'd5,
		CMD_ADD   = 3'd6,  // fold working vars into chaining value
		CMD_REARM = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t        op;
		logic [31:0] data;
	} sha_cmd_t;

	typedef struct packed {
		logic [4:0] fill;   // 0..16
		logic [5:0] round;
	} sha_stat_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t round_k(input logic [5:0] r);
		word_t k [64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_k = k[r];
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		word_t h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		init_hash = h[i];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/sha_datapath.sv -----
`default_nettype none
module sha_datapath import sha_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sha_cmd_t  cmd,
	input  wire logic [2:0] rd_index,
	output word_t          rd_word,
	output sha_stat_t      stat
);
	word_t cv_q [8];
	word_t wv_q [8];
	word_t win_q [16];
	logic [4:0] fill_q;
	logic [5:0] round_q;

	logic [3:0] j;
	word_t wa, wb, s0w, s1w, wj, t1, t2, s0, s1, ch, maj;

	assign j = round_q[3:0];
	assign stat = '{fill: fill_q, round: round_q};
	assign rd_word = cv_q[rd_index];

	always_comb begin
		wa  = win_q[j + 4'd1];
		wb  = win_q[j + 4'd14];
		s0w = rotr(wa, 7) ^ rotr(wa, 18) ^ (wa >> 3);
		s1w = rotr(wb, 17) ^ rotr(wb, 19) ^ (wb >> 10);
		wj  = (round_q >= 6'd16) ? win_q[j] + s0w + win_q[j + 4'd9] + s1w : win_q[j];
		s1  = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
		ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		t1  = wv_q[7] + s1 + ch + round_k(round_q) + wj;
		s0  = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
		maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t2  = s0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= init_hash(3'(i));
		end else begin
			case (cmd.op)
				CMD_PUT, CMD_ZERO, CMD_LEN: begin
					win_q[fill_q[3:0]] <= (cmd.op == CMD_ZERO) ? '0 : cmd.data;
					fill_q <= fill_q + 5'd1;
				end
				CMD_START: begin
					round_q <= '0;
					for (int i = 0; i < 8; i++) wv_q[i] <= cv_q[i];
				end
				CMD_ROUND: begin
					win_q[j] <= wj;
					round_q <= round_q + 6'd1;
					wv_q[7] <= wv_q[6]; wv_q[6] <= wv_q[5]; wv_q[5] <= wv_q[4];
					wv_q[4] <= wv_q[3] + t1;
					wv_q[3] <= wv_q[2]; wv_q[2] <= wv_q[1]; wv_q[1] <= wv_q[0];
					wv_q[0] <= t1 + t2;
				end
				CMD_ADD: begin
					fill_q <= '0;
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + wv_q[i];
				end
				CMD_REARM: begin
					fill_q <= '0;
					for (int i = 0; i < 8; i++) cv_q[i] <= init_hash(3'(i));
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sha_ctrl.sv -----
`default_nettype none
module sha_ctrl import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] in_word,
	input  wire logic [2:0]  in_vb,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_index,
	input  wire sha_stat_t   stat,
	output sha_cmd_t         cmd
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PAD80 = 8'b0000_0010,  // append 0x80 word after a full last word
		S_FILL  = 8'b0000_0100,  // zero fill up to the length words; stores the high length word
		S_START = 8'b0000_1000,
		S_RUN   = 8'b0001_0000,
		S_ADD   = 8'b0010_0000,
		S_OUT   = 8'b0100_0000,
		S_LENLO = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [63:0] len_q;
	logic fin_q;      // message ended: padding in progress
	logic pad_q;      // 0x80 word still owed after the next compression
	logic lenblk_q;   // the block being compressed carries the length words
	logic [2:0] idx_q;
	logic [2:0] vb;
	logic [63:0] len_nx;
	word_t mask, padw;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_index = idx_q;

	always_comb begin
		vb = in_last ? ((in_vb > 3'd4) ? 3'd4 : in_vb) : 3'd4;
		len_nx = len_q + {58'd0, vb, 3'd0};
		mask = (vb == 3'd0) ? '0 : ('1 << {(3'd4 - vb), 3'd0});
		padw = 32'h80 << {(2'd3 - vb[1:0]), 3'd0};
	end

	always_comb begin
		cmd = '{op: CMD_NONE, data: '0};
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = CMD_PUT;
				cmd.data = (vb == 3'd4) ? in_word : ((in_word & mask) | padw);
			end
			S_PAD80: cmd = '{op: CMD_PUT, data: PadWord};
			S_FILL:  cmd = (stat.fill == 5'd14) ? '{op: CMD_LEN, data: len_q[63:32]}
				: '{op: CMD_ZERO, data: '0};
			S_LENLO: cmd = '{op: CMD_LEN, data: len_q[31:0]};
			S_START: cmd.op = CMD_START;
			S_RUN:   cmd.op = CMD_ROUND;
			S_ADD:   cmd.op = CMD_ADD;
			S_OUT:   if (out_ready && idx_q == 3'd7) cmd.op = CMD_REARM;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			fin_q <= 1'b0;
			pad_q <= 1'b0;
			lenblk_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					len_q <= len_nx;
					if (in_last) begin
						fin_q <= 1'b1;
						if (vb == 3'd4 && stat.fill == 5'd15) begin
							pad_q <= 1'b1;
							state_q <= S_START;
						end else if (vb == 3'd4) state_q <= S_PAD80;
						else if (stat.fill == 5'd15) state_q <= S_START;
						else state_q <= S_FILL;
					end else if (stat.fill == 5'd15) state_q <= S_START;
				end
				S_PAD80: state_q <= (stat.fill == 5'd15) ? S_START : S_FILL;
				S_FILL: begin
					if (stat.fill == 5'd15) state_q <= S_START;
					else if (stat.fill == 5'd14) state_q <= S_LENLO;
				end
				S_LENLO: begin
					lenblk_q <= 1'b1;
					state_q <= S_START;
				end
				S_START: state_q <= S_RUN;
				S_RUN: if (stat.round == 6'(Rounds - 1)) state_q <= S_ADD;
				S_ADD: begin
					// Mid-message, return to idle; after the length block, show the digest; otherwise resume padding.
					if (!fin_q) state_q <= S_IDLE;
					else if (pad_q) begin
						pad_q <= 1'b0;
						state_q <= S_PAD80;
					end else if (lenblk_q) state_q <= S_OUT;
					else state_q <= S_FILL;
					lenblk_q <= 1'b0;
					idx_q <= '0;
				end
				S_OUT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						state_q <= S_IDLE;
						fin_q <= 1'b0;
						len_q <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sha256_stream_hash.sv -----
// Channel  Dir  Payload
// s_axis   in   tdata[31:0] message_word, tuser[2:0] valid_bytes, tlast last_item
// m_axis   out  tdata[31:0] digest_word, tuser[2:0] digest_index, tlast digest_last
// A non-final word is stored as it is taken; the 16th word of a block also starts
// a compression (load, 64 rounds through the single round unit, fold).
// A final word costs one or two compressions plus padding with zero fill and the
// length words, then eight result words, which stall while m_axis_tready is low.
// Reset loads the initial hash value; no request is taken while busy.
`default_nettype none
module sha256_stream_hash import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // message_word
	input  wire logic [2:0]  s_axis_tuser,   // valid_bytes
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // digest_word
	output logic [2:0]       m_axis_tuser,   // digest_index
	output logic             m_axis_tlast
);
	sha_cmd_t  cmd;
	sha_stat_t stat;
	logic [2:0] idx;

	sha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_word(s_axis_tdata), .in_vb(s_axis_tuser), .in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_index(idx),
		.stat, .cmd
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .rd_index(idx), .rd_word(m_axis_tdata), .stat
	);

	assign m_axis_tuser = idx;
	assign m_axis_tlast = (idx == 3'd7);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input taken while emitting");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= 5'd16) else $error("fill overflow");
	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("digest overran");
`endif
endmodule
`default_nettype wire

// ----- test/sha256_stream_hash_checker.sv -----
`default_nettype none
module sha256_stream_hash_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // message_word
	input  wire logic [2:0]  s_axis_tuser,   // valid_bytes
	input  wire logic        s_axis_tlast,   // last_item
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,   // digest_word
	input  wire logic [2:0]  m_axis_tuser,   // digest_index
	input  wire logic        m_axis_tlast,   // digest_last
	output int               fail_count,
	output int               pending_words
);
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_t;

	localparam logic [31:0] HashK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] HashInit [8] = '{32'h6a09e667, 32'hbb67ae85,
		32'h3c6ef372, 32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab,
		32'h5be0cd19};

	logic [31:0] state_h [8];
	logic [31:0] block_w [16];
	logic [63:0] msg_bits;
	int          word_count;
	digest_t     digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] v [8];
		logic [31:0] t1, t2, a, b;
		int j;
		for (int i = 0; i < 8; i++) v[i] = state_h[i];
		for (int r = 0; r < 64; r++) begin
			j = r % 16;
			if (r >= 16) begin
				a = block_w[(j + 1) % 16];
				b = block_w[(j + 14) % 16];
				block_w[j] += (ror(a, 7) ^ ror(a, 18) ^ (a >> 3)) + block_w[(j + 9) % 16]
					+ (ror(b, 17) ^ ror(b, 19) ^ (b >> 10));
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + HashK[r] + block_w[j];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) state_h[i] += v[i];
	endtask

	task automatic append_word(input logic [31:0] w);
		block_w[word_count] = w;
		word_count++;
		if (word_count == 16) begin
			compress();
			word_count = 0;
		end
	endtask

	task automatic absorb(input logic [31:0] w, input logic [2:0] nbytes, input logic fin);
		int n;
		logic [31:0] mask;
		if (!fin) begin
			msg_bits += 32;
			append_word(w);
			return;
		end
		n = (nbytes > 4) ? 4 : nbytes;
		msg_bits += 64'(n * 8);
		if (n == 4) begin
			append_word(w);
			block_w[word_count] = 32'h8000_0000;
			word_count++;
		end else begin
			mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - n)));
			block_w[word_count] = (w & mask) | (32'h80 << (8 * (3 - n)));
			word_count++;
		end
		// Length does not fit after the pad byte: close this block first.
		if (word_count > 14) begin
			for (int i = word_count; i < 16; i++) block_w[i] = 0;
			compress();
			word_count = 0;
		end
		for (int i = word_count; i < 14; i++) block_w[i] = 0;
		block_w[14] = msg_bits[63:32];
		block_w[15] = msg_bits[31:0];
		compress();
		for (int i = 0; i < 8; i++)
			digest_q.push_back('{state_h[i], 3'(i), i == 7});
		for (int i = 0; i < 8; i++) state_h[i] = HashInit[i];
		msg_bits = 0;
		word_count = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) state_h[i] = HashInit[i];
			msg_bits = 0;
			word_count = 0;
			digest_q.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					$error("digest word 0x%h with nothing expected", m_axis_tdata);
					fail_count++;
				end else begin
					want = digest_q.pop_front();
					if (m_axis_tdata !== want.word) begin
						$error("digest_word expected %h actual %h", want.word, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser !== want.index) begin
						$error("digest_index expected %0d actual %0d", want.index, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("digest_last expected %0d actual %0d", want.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
		end
		pending_words = digest_q.size();
	end
endmodule
`default_nettype wire

// ----- test/sha256_stream_hash_tb.sv -----
`default_nettype none
module sha256_stream_hash_tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 0;   // message_word
	logic [2:0]  s_axis_tuser = 0;   // valid_bytes
	logic        s_axis_tlast = 0;   // last_item
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;       // digest_word
	logic [2:0]  m_axis_tuser;       // digest_index
	logic        m_axis_tlast;       // digest_last
	int          fail_count;
	int          pending_words;
	int          cycle_count = 0;
	bit          hold_off_done = 0;

	sha256_stream_hash DUT (.*);
	sha256_stream_hash_checker checker_i (.*);

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("sha256_stream_hash: mismatch");
			$finish;
		end
	end

	// Receiver: one long hold-off after the first digest shows up, then a random pattern.
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_off_done && m_axis_tvalid) begin
				hold_off_done = 1;
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
			end
			mode = (cycle_count / 2000) % 3;
			if (mode == 0) m_axis_tready <= 1;
			else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
			else m_axis_tready <= ($urandom_range(0, 3) == 0);
		end
	end

	int burst_left = 0;

	// A burst ends with valid dropped; the next burst waits a random gap before it starts.
	task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic fin);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1;
		s_axis_tdata <= w;
		s_axis_tuser <= nb;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left == 0) s_axis_tvalid <= 0;
	endtask

	task automatic end_burst();
		if (burst_left != 0) begin
			s_axis_tvalid <= 0;
			burst_left = 0;
		end
	endtask

	task automatic send_message(input int nwords, input logic [2:0] tail_bytes,
			input int pattern);
		logic [31:0] w;
		for (int i = 0; i < nwords; i++) begin
			case (pattern)
				0: w = 32'h0;
				1: w = 32'hffff_ffff;
				default: w = $urandom();
			endcase
			// Non-final words carry random byte counts, which must be ignored.
			send_word(w, 3'($urandom_range(0, 7)), 1'b0);
		end
		w = (pattern == 0) ? 32'h0 : (pattern == 1) ? 32'hffff_ffff : $urandom();
		send_word(w, tail_bytes, 1'b1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty message, tail lengths 0 to 5 and 7, padding overflow, all-ones data.
		send_message(0, 3'd0, 0);
		send_message(0, 3'd4, 1);
		send_message(0, 3'd7, 1);
		send_message(13, 3'd4, 2);
		send_message(14, 3'd3, 1);
		send_message(15, 3'd0, 0);
		send_message(15, 3'd4, 2);
		send_message(1, 3'd1, 2);
		send_message(2, 3'd2, 2);
		send_message(3, 3'd5, 2);
		end_burst();
		while (pending_words != 0 || cycle_count < 0) @(posedge clk);
		// Random messages, mostly short, a few spanning several blocks.
		for (int m = 0; m < 5; m++)
			send_message(($urandom_range(0, 5) == 0) ? $urandom_range(14, 34)
				: $urandom_range(0, 8), 3'($urandom_range(0, 7)), 2);
		end_burst();
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("sha256_stream_hash: match");
		else
			$display("sha256_stream_hash: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sha256_stream_hash.f -----
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hash.sv
test/sha256_stream_hash_checker.sv
test/sha256_stream_hash_tb.sv
